### rtl/uer_pkg.sv
package uer_pkg;

  localparam int unsigned CountWidth = 17;
  localparam int unsigned DistWidth  = 12;
  localparam int unsigned RemWidth   = 14;

  localparam logic [CountWidth-1:0] PRE_LOW_TICKS      = CountWidth'(5);
  localparam logic [CountWidth-1:0] TRIGGER_HIGH_TICKS = CountWidth'(10);

  // distance = floor(count * 332 / 10000), kept as quotient and remainder
  localparam logic [RemWidth-1:0] REM_STEP    = RemWidth'(332);
  localparam logic [RemWidth-1:0] REM_DIVISOR = RemWidth'(10000);

  localparam logic [3:0] CFG_MIN_DISTANCE = 4'd0;
  localparam logic [3:0] CFG_MAX_DISTANCE = 4'd1;
  localparam logic [3:0] CFG_RISE_LIMIT   = 4'd2;
  localparam logic [3:0] CFG_ECHO_LIMIT   = 4'd3;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_NO_ECHO   = 3'd1,
    STATUS_TIMEOUT   = 3'd2,
    STATUS_FAULT     = 3'd3,
    STATUS_OUT_RANGE = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'b00001,
    PH_PRE_LOW   = 5'b00010,
    PH_TRIG_HIGH = 5'b00100,
    PH_WAIT_RISE = 5'b01000,
    PH_ECHO_HIGH = 5'b10000
  } phase_e;

  typedef struct packed {
    logic signed [12:0] min_distance;
    logic signed [12:0] max_distance;
    logic [15:0]        rise_limit;
    logic [15:0]        echo_limit;
  } cfg_t;

  typedef struct packed {
    logic                 trigger_level;
    logic                 busy_res;
    logic                 done_res;
    logic [2:0]           status;
    logic [DistWidth-1:0] distance;
  } res_t;

endpackage

### rtl/ultrasonic_echo_ranger.sv
// channel   | handshake                  | payload
// input     | in_valid_i / in_stall_o    | req_type_i, echo_level_i, disturbed_i
// result    | out_valid_o / out_stall_i  | trigger_level_o, busy_res_o, done_res_o,
//           |                            | status_o, distance_o
// config    | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// one item per cycle while the input is not stalled; each item yields one result in the cycle after acceptance
// the state update and result logic sit between the input port and the result register
// input stalls only while a result is held and the result side stalls
// reset returns the phase to idle, clears the tick counter and loads config defaults
// config is always ready
module ultrasonic_echo_ranger (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic        echo_level_i,
  input  logic        disturbed_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        trigger_level_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [2:0]  status_o,
  output logic [11:0] distance_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  uer_pkg::cfg_t cfg_q;
  uer_pkg::res_t res, res_q;
  logic          out_valid_q, out_valid_d;
  logic          accept;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_distance <= 13'h1FFF;
      cfg_q.max_distance <= 13'h1FFF;
      cfg_q.rise_limit   <= 16'd255;
      cfg_q.echo_limit   <= 16'd1920;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        uer_pkg::CFG_MIN_DISTANCE: cfg_q.min_distance <= cfg_data_i[12:0];
        uer_pkg::CFG_MAX_DISTANCE: cfg_q.max_distance <= cfg_data_i[12:0];
        uer_pkg::CFG_RISE_LIMIT:   cfg_q.rise_limit   <= cfg_data_i;
        uer_pkg::CFG_ECHO_LIMIT:   cfg_q.echo_limit   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  uer_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (accept),
    .start_i     (req_type_i),
    .echo_i      (echo_level_i),
    .disturbed_i (disturbed_i),
    .cfg_i       (cfg_q),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign trigger_level_o = res_q.trigger_level;
  assign busy_res_o      = res_q.busy_res;
  assign done_res_o      = res_q.done_res;
  assign status_o        = res_q.status;
  assign distance_o      = res_q.distance;

endmodule

### rtl/uer_core.sv
module uer_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic          start_i,
  input  logic          echo_i,
  input  logic          disturbed_i,
  input  uer_pkg::cfg_t cfg_i,
  output uer_pkg::res_t res_o
);

  uer_pkg::phase_e                     phase_q, phase_d;
  logic [uer_pkg::CountWidth-1:0]      cnt_q, cnt_d, cnt_inc;
  logic                                fault_q, fault_d, fault_now;
  logic [uer_pkg::DistWidth-1:0]       dist_q, dist_d;
  logic [uer_pkg::RemWidth-1:0]        rem_q, rem_d, rem_sum;
  logic                                busy, finish, in_range;
  uer_pkg::status_e                    err;
  uer_pkg::res_t                       res;

  assign busy = (phase_q == uer_pkg::PH_PRE_LOW) || (phase_q == uer_pkg::PH_TRIG_HIGH) ||
                (phase_q == uer_pkg::PH_WAIT_RISE) || (phase_q == uer_pkg::PH_ECHO_HIGH);
  assign cnt_inc   = cnt_q + uer_pkg::CountWidth'(1);
  assign rem_sum   = rem_q + uer_pkg::REM_STEP;
  assign fault_now = fault_q | disturbed_i;
  assign in_range  = ($signed({1'b0, dist_q}) > cfg_i.min_distance) &&
                     ($signed({1'b0, dist_q}) < cfg_i.max_distance);

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    fault_d = fault_q;
    dist_d  = dist_q;
    rem_d   = rem_q;
    finish  = 1'b0;
    err     = uer_pkg::STATUS_OK;
    res     = '0;
    if (start_i) begin
      if (!busy) begin
        phase_d = uer_pkg::PH_PRE_LOW;
        cnt_d   = '0;
        fault_d = 1'b0;
      end
      res.busy_res      = 1'b1;
      res.trigger_level = busy && (phase_q == uer_pkg::PH_TRIG_HIGH);
    end else if (!busy) begin
      phase_d = uer_pkg::PH_IDLE;
    end else begin
      fault_d = fault_now;
      case (phase_q)
        uer_pkg::PH_PRE_LOW: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= uer_pkg::PRE_LOW_TICKS) begin
            phase_d = uer_pkg::PH_TRIG_HIGH;
            cnt_d   = '0;
          end
        end
        uer_pkg::PH_TRIG_HIGH: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= uer_pkg::TRIGGER_HIGH_TICKS) begin
            phase_d = uer_pkg::PH_WAIT_RISE;
            cnt_d   = '0;
          end
        end
        uer_pkg::PH_WAIT_RISE: begin
          if (!echo_i) begin
            cnt_d = cnt_inc;
            if (cnt_inc > {1'b0, cfg_i.rise_limit}) begin
              finish = 1'b1;
              err    = uer_pkg::STATUS_NO_ECHO;
            end
          end else begin
            phase_d = uer_pkg::PH_ECHO_HIGH;
            cnt_d   = uer_pkg::CountWidth'(1);
            dist_d  = '0;
            rem_d   = uer_pkg::REM_STEP;
            if (cfg_i.echo_limit == '0) begin
              finish = 1'b1;
              err    = uer_pkg::STATUS_TIMEOUT;
            end
          end
        end
        uer_pkg::PH_ECHO_HIGH: begin
          if (echo_i) begin
            cnt_d = cnt_inc;
            if (rem_sum >= uer_pkg::REM_DIVISOR) begin
              rem_d  = rem_sum - uer_pkg::REM_DIVISOR;
              dist_d = dist_q + uer_pkg::DistWidth'(1);
            end else begin
              rem_d = rem_sum;
            end
            if (cnt_inc > {1'b0, cfg_i.echo_limit}) begin
              finish = 1'b1;
              err    = uer_pkg::STATUS_TIMEOUT;
            end
          end else begin
            finish = 1'b1;
            err    = uer_pkg::STATUS_OK;
          end
        end
        default: begin
          phase_d = uer_pkg::PH_IDLE;
        end
      endcase
      res.busy_res      = 1'b1;
      res.trigger_level = (phase_d == uer_pkg::PH_TRIG_HIGH);
      if (finish) begin
        phase_d           = uer_pkg::PH_IDLE;
        cnt_d             = '0;
        fault_d           = 1'b0;
        res.trigger_level = 1'b0;
        res.busy_res      = 1'b0;
        res.done_res      = 1'b1;
        if (fault_now) begin
          res.status = uer_pkg::STATUS_FAULT;
        end else if (err == uer_pkg::STATUS_OK) begin
          if (in_range) begin
            res.distance = dist_q;
          end else begin
            res.status = uer_pkg::STATUS_OUT_RANGE;
          end
        end else begin
          res.status = err;
        end
      end
    end
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= uer_pkg::PH_IDLE;
      cnt_q   <= '0;
      fault_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      fault_q <= fault_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      dist_q <= dist_d;
      rem_q  <= rem_d;
    end
  end

endmodule

### rtl/uer_checker.sv
module uer_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        trigger_level_o,
  input logic        busy_res_o,
  input logic        done_res_o,
  input logic [2:0]  status_o,
  input logic [11:0] distance_o
);

  // input side only stalls behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // status and distance are zero unless a measurement finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !done_res_o) |->
      (status_o == uer_pkg::STATUS_OK && distance_o == 12'd0))
    else $error("status or distance set without done");

  // a finished measurement is no longer busy and drives trigger low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && done_res_o) |-> (!busy_res_o && !trigger_level_o))
    else $error("done result still busy or triggering");

  // distance only on a good status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != uer_pkg::STATUS_OK) |-> (distance_o == 12'd0))
    else $error("distance reported on an error status");

  // a stalled transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(status_o) && $stable(distance_o) && $stable(done_res_o)))
    else $error("stalled result changed");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .trigger_level_o (trigger_level_o),
  .busy_res_o      (busy_res_o),
  .done_res_o      (done_res_o),
  .status_o        (status_o),
  .distance_o      (distance_o)
);

### bench/ultrasonic_echo_ranger_tb.sv
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_tb;
  import uer_pkg::*;

  localparam int unsigned DIST_NUM = 332;
  localparam int unsigned DIST_DEN = 10000;
  localparam int PHASE_ITEMS = 240;
  localparam int PHASE_DONE = 8;
  localparam int NUM_SETTINGS = 6;
  localparam int MAX_PRINTED = 40;

  class ranger_scoreboard;
    logic signed [12:0] min_dist;
    logic signed [12:0] max_dist;
    logic [15:0] rise_lim;
    logic [15:0] echo_lim;
    phase_e phase;
    logic [CountWidth-1:0] ticks;
    bit fault;
    res_t expected_q[$];
    int n_active;
    int n_results;
    int n_done;
    int n_errors;
    int status_count[5];

    function new();
      min_dist = '1;
      max_dist = '1;
      rise_lim = 16'd255;
      echo_lim = 16'd1920;
      phase = PH_IDLE;
      ticks = '0;
      fault = 1'b0;
    endfunction

    function bit busy();
      return phase != PH_IDLE;
    endfunction

    function void write_reg(logic [3:0] idx, logic [15:0] data);
      case (idx)
        CFG_MIN_DISTANCE: min_dist = data[12:0];
        CFG_MAX_DISTANCE: max_dist = data[12:0];
        CFG_RISE_LIMIT:   rise_lim = data;
        CFG_ECHO_LIMIT:   echo_lim = data;
        default: ;
      endcase
    endfunction

    function res_t close_measurement(status_e err, logic [CountWidth-1:0] count);
      res_t r;
      int unsigned d;
      r = '0;
      r.done_res = 1'b1;
      r.status = err;
      if (fault) begin
        r.status = STATUS_FAULT;
      end else if (err == STATUS_OK) begin
        d = (32'(count) * DIST_NUM) / DIST_DEN;
        if (int'(d) > int'(min_dist) && int'(d) < int'(max_dist)) begin
          r.distance = DistWidth'(d);
        end else begin
          r.status = STATUS_OUT_RANGE;
        end
      end
      phase = PH_IDLE;
      ticks = '0;
      fault = 1'b0;
      return r;
    endfunction

    // advance the ranging state by one accepted input transaction
    function void note_request(logic is_start, logic echo, logic disturbed);
      res_t r;
      bit ended;
      status_e err;
      r = '0;
      ended = 1'b0;
      err = STATUS_OK;
      if (is_start || busy()) n_active++;
      if (is_start) begin
        if (!busy()) begin
          phase = PH_PRE_LOW;
          ticks = '0;
          fault = 1'b0;
        end
      end else if (busy()) begin
        if (disturbed) fault = 1'b1;
        case (phase)
          PH_PRE_LOW: begin
            ticks++;
            if (ticks >= PRE_LOW_TICKS) begin
              phase = PH_TRIG_HIGH;
              ticks = '0;
            end
          end
          PH_TRIG_HIGH: begin
            ticks++;
            if (ticks >= TRIGGER_HIGH_TICKS) begin
              phase = PH_WAIT_RISE;
              ticks = '0;
            end
          end
          PH_WAIT_RISE: begin
            if (!echo) begin
              ticks++;
              if (ticks > rise_lim) begin
                ended = 1'b1;
                err = STATUS_NO_ECHO;
              end
            end else begin
              phase = PH_ECHO_HIGH;
              ticks = 1;
              if (ticks > echo_lim) begin
                ended = 1'b1;
                err = STATUS_TIMEOUT;
              end
            end
          end
          PH_ECHO_HIGH: begin
            if (echo) begin
              ticks++;
              if (ticks > echo_lim) begin
                ended = 1'b1;
                err = STATUS_TIMEOUT;
              end
            end else begin
              ended = 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (ended) begin
        r = close_measurement(err, ticks);
      end else if (busy()) begin
        r.busy_res = 1'b1;
        r.trigger_level = (phase == PH_TRIG_HIGH);
      end
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      if (n_errors < MAX_PRINTED) $display("%0t mismatch: %s", $realtime, msg);
      n_errors++;
    endtask

    task check_result(res_t got);
      res_t want;
      n_results++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", n_results));
        return;
      end
      want = expected_q.pop_front();
      if (want.done_res) begin
        n_done++;
        status_count[want.status]++;
      end
      if (got.trigger_level !== want.trigger_level)
        report($sformatf("result %0d trigger_level got %b want %b", n_results,
                         got.trigger_level, want.trigger_level));
      if (got.busy_res !== want.busy_res)
        report($sformatf("result %0d busy_res got %b want %b", n_results,
                         got.busy_res, want.busy_res));
      if (got.done_res !== want.done_res)
        report($sformatf("result %0d done_res got %b want %b", n_results,
                         got.done_res, want.done_res));
      if (got.status !== want.status)
        report($sformatf("result %0d status got %0d want %0d", n_results,
                         got.status, want.status));
      if (got.distance !== want.distance)
        report($sformatf("result %0d distance got %0d want %0d", n_results,
                         got.distance, want.distance));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        req_type_i = 1'b0;
  logic        echo_level_i = 1'b0;
  logic        disturbed_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        trigger_level_o;
  logic        busy_res_o;
  logic        done_res_o;
  logic [2:0]  status_o;
  logic [11:0] distance_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  int send_idle_pct = 14;
  int recv_idle_pct = 57;
  ranger_scoreboard sb;

  // min, max, rise limit, echo limit; upper bits of the distance words are dropped
  logic [15:0] setting_data [NUM_SETTINGS][4] = '{
    '{16'hFFFF, 16'h0FFF, 16'd30,   16'd150},
    '{16'hE002, 16'h0009, 16'd1,    16'd400},
    '{16'h0FFF, 16'hFFFF, 16'd0,    16'd0},
    '{16'h1000, 16'h0006, 16'hFFFF, 16'hFFFF},
    '{16'hFFFF, 16'hA3E8, 16'd20,   16'd600},
    '{16'hFFFF, 16'h0FFF, 16'd200,  16'hFFFF}
  };

  ultrasonic_echo_ranger dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .echo_level_i   (echo_level_i),
    .disturbed_i    (disturbed_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .trigger_level_o(trigger_level_o),
    .busy_res_o     (busy_res_o),
    .done_res_o     (done_res_o),
    .status_o       (status_o),
    .distance_o     (distance_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(res_t'({trigger_level_o, busy_res_o, done_res_o, status_o,
                              distance_o}));
    end
  end

  // hold each transaction until accepted; valid is only lowered in a gap
  task automatic send_item(logic is_start, logic echo, logic disturbed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= is_start;
    echo_level_i <= echo;
    disturbed_i <= disturbed;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(is_start, echo, disturbed);
  endtask

  task automatic tick(logic echo, bit noisy);
    if (noisy && $urandom_range(32) == 0)
      send_item(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)));
    send_item(1'b0, echo, noisy && $urandom_range(399) == 0);
  endtask

  task automatic measure(int unsigned low_ticks, int unsigned high_ticks, bit noisy);
    int unsigned i;
    send_item(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)));
    for (i = 0; i < int'(PRE_LOW_TICKS + TRIGGER_HIGH_TICKS); i++)
      tick(1'($urandom_range(1)), noisy);
    for (i = 0; i < low_ticks && sb.busy(); i++) tick(1'b0, noisy);
    for (i = 0; i < high_ticks && sb.busy(); i++) tick(1'b1, noisy);
    if (sb.busy()) tick(1'b0, noisy);
  endtask

  // bring any open measurement to its end
  task automatic settle();
    while (sb.busy()) send_item(1'b0, 1'(sb.phase == PH_WAIT_RISE), 1'b0);
  endtask

  function automatic int unsigned low_len(logic [15:0] lim);
    if (lim <= 300 && $urandom_range(4) == 0) return 32'(lim) + 1;
    return $urandom_range(0, (lim < 12) ? 32'(lim) : 12);
  endfunction

  function automatic int unsigned high_len(logic [15:0] lim);
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5, 6: return $urandom_range(1, 30);
      7, 8: return $urandom_range(31, 150);
      default: begin
        if (lim <= 400) return 32'(lim) + $urandom_range(0, 2);
        return $urandom_range(150, 400);
      end
    endcase
  endfunction

  task automatic cfg_write(logic [3:0] idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic load_setting(int s);
    cfg_write(4'($urandom_range(4, 15)), 16'($urandom));
    cfg_write(CFG_MIN_DISTANCE, setting_data[s][0]);
    cfg_write(CFG_MAX_DISTANCE, setting_data[s][1]);
    cfg_write(CFG_RISE_LIMIT, setting_data[s][2]);
    cfg_write(CFG_ECHO_LIMIT, setting_data[s][3]);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0 && guard < 10000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_random();
    int active0;
    int done0;
    active0 = sb.n_active;
    done0 = sb.n_done;
    while (sb.n_active - active0 < PHASE_ITEMS || sb.n_done - done0 < PHASE_DONE) begin
      repeat ($urandom_range(3))
        send_item(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)));
      if ($urandom_range(9) == 0) begin
        send_item(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)));
        repeat ($urandom_range(20, 60))
          send_item(1'b0, 1'($urandom_range(1)), 1'($urandom_range(9) == 0));
        settle();
      end
      measure(low_len(sb.rise_lim), high_len(sb.echo_lim), 1'b1);
      settle();
    end
  endtask

  initial begin
    #40_000_000;
    $display("ultrasonic_echo_ranger_tb: done, errors");
    $finish;
  end

  initial begin
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: idle tick, start with ignored pins, start while busy,
    // fault on the finishing tick
    send_item(1'b0, 1'b1, 1'b1);
    send_item(1'b1, 1'b1, 1'b1);
    repeat (7) send_item(1'b0, 1'b1, 1'b0);
    send_item(1'b1, 1'b0, 1'b0);
    repeat (10) send_item(1'b0, 1'b0, 1'b0);
    repeat (3) send_item(1'b0, 1'b1, 1'b0);
    send_item(1'b0, 1'b0, 1'b1);
    drain();

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      case (s / 2)
        0: begin
          send_idle_pct = 14;
          recv_idle_pct = 57;
        end
        1: begin
          send_idle_pct = 57;
          recv_idle_pct = 14;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      load_setting(s);
      run_random();
      drain();
    end

    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
    $display("summary: %0d results checked from %0d active inputs, %0d measurements",
             sb.n_results, sb.n_active, sb.n_done);
    $display("summary: ok %0d, no echo %0d, timeout %0d, fault %0d, out of range %0d",
             sb.status_count[STATUS_OK], sb.status_count[STATUS_NO_ECHO],
             sb.status_count[STATUS_TIMEOUT], sb.status_count[STATUS_FAULT],
             sb.status_count[STATUS_OUT_RANGE]);
    if (sb.n_errors == 0) begin
      $display("ultrasonic_echo_ranger_tb: done, clean");
    end else begin
      $display("ultrasonic_echo_ranger_tb: done, errors");
    end
    $finish;
  end

endmodule
